>>> src/bfa_pkg.sv
// Shared constants, codes and types for the bitmap frame allocator.
package bfa_pkg;

	localparam int MAX_BLOCKS  = 32768;
	localparam int WORD_BITS   = 32;
	localparam int BLOCK_BYTES = 4096;
	localparam int ADDR_W      = 32;
	localparam int CNT_W       = 16;

	localparam int BLK_SHIFT = $clog2(BLOCK_BYTES);
	localparam int BIT_W     = $clog2(WORD_BITS);
	localparam int BLK_W     = $clog2(MAX_BLOCKS);
	localparam int MAP_WORDS = MAX_BLOCKS / WORD_BITS;
	localparam int MAP_AW    = $clog2(MAP_WORDS);
	localparam int PCNT_W    = BIT_W + 1;
	localparam int BIDX_W    = ADDR_W - BLK_SHIFT;
	localparam int WCNT_W    = CNT_W - BIT_W;
	localparam int SRCH_W    = ADDR_W - BLK_SHIFT - BIT_W + 1;

	localparam logic [1:0] OP_RESERVE = 2'd0;
	localparam logic [1:0] OP_FREE    = 2'd1;
	localparam logic [1:0] OP_ALLOC   = 2'd2;
	localparam logic [1:0] OP_RELEASE = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_MISALIGN = 2'd1;
	localparam logic [1:0] ST_NOMEM    = 2'd2;

	typedef logic [WORD_BITS-1:0] word_t;

	typedef struct packed {
		word_t            data;
		logic [BIT_W-1:0] lo;
		logic [BIT_W-1:0] hi;
		logic             mark;
	} wop_req_t;

	typedef struct packed {
		word_t             range_word;
		logic [PCNT_W-1:0] changed;
		logic              full;
		logic [BIT_W-1:0]  zero_idx;
		word_t             alloc_word;
	} wop_rsp_t;

endpackage

>>> src/bfa_map_ram.sv
// Generic single-port-write, registered-read RAM for the used-block map.
module bfa_map_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 32,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/bfa_word_unit.sv
// Word modify logic: range mark/clear with change count, and first-free search.
module bfa_word_unit
	import bfa_pkg::*;
(
	input  wop_req_t req,
	output wop_rsp_t rsp
);

	word_t             mask;
	word_t             flip;
	logic [PCNT_W-1:0] cnt;
	logic [BIT_W-1:0]  zidx;

	// build the bit range mask and the bits that actually change
	always_comb begin
		mask = ({WORD_BITS{1'b1}} << req.lo) &
		       ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - req.hi));
		flip = req.mark ? (mask & ~req.data) : (mask & req.data);
	end

	// count changed bits
	always_comb begin
		cnt = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			cnt = cnt + PCNT_W'(flip[i]);
		end
	end

	// lowest clear bit, scanned from the top so the lowest wins
	always_comb begin
		zidx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (!req.data[i]) begin
				zidx = BIT_W'(i);
			end
		end
	end

	always_comb begin
		rsp.range_word = req.mark ? (req.data | mask) : (req.data & ~mask);
		rsp.changed    = cnt;
		rsp.full       = &req.data;
		rsp.zero_idx   = zidx;
		rsp.alloc_word = req.data | (word_t'(1) << zidx);
	end

endmodule

>>> src/bitmap_frame_allocator.sv
// Bitmap frame allocator: map memory, word sequencer and result register.
// Misaligned or empty requests go straight to the done state; region and release ops read
//   and rewrite each map word touched, allocation reads each word scanned, then the result is registered.
// One op at a time; the map memory read-modify-write loop sets the rate.
// Reset clears the used count and total to zero; every total_blocks write starts a
//   fill pass setting all 1024 map words, during which no word is accepted.
module bitmap_frame_allocator
	import bfa_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CNT_W-1:0]    total_blocks,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [ADDR_W-1:0]   addr,
	input  logic [ADDR_W-1:0]   length,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [1:0]          status,
	output logic [ADDR_W-1:0]   result_addr,
	output logic [CNT_W-1:0]    used_count,
	output logic [CNT_W-1:0]    free_count
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FILL = 3'd1;
	localparam logic [2:0] S_RD   = 3'd2;
	localparam logic [2:0] S_MOD  = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0]          state_q;
	logic [MAP_AW-1:0]   fill_q;
	logic [CNT_W-1:0]    total_q;
	logic [CNT_W-1:0]    used_q;
	logic                alloc_q;
	logic                mark_q;
	logic [MAP_AW-1:0]   w_q;
	logic [MAP_AW-1:0]   last_w_q;
	logic [BIT_W-1:0]    lo_q;
	logic [BIT_W-1:0]    hi_last_q;
	logic [1:0]          st_q;
	logic [ADDR_W-1:0]   raddr_q;

	logic                out_valid_q;
	logic [1:0]          status_q;
	logic [ADDR_W-1:0]   result_addr_q;
	logic [CNT_W-1:0]    used_count_q;
	logic [CNT_W-1:0]    free_count_q;

	logic [CNT_W-1:0]    cfg_sat;
	logic                accept;
	logic                misaligned;
	logic [BIDX_W-1:0]   first_blk;
	logic [BIDX_W:0]     stop_raw;
	logic [BIDX_W:0]     stop_c;
	logic [BIDX_W:0]     last_blk;
	logic                region_empty;
	logic                rel_in_range;
	logic [SRCH_W-1:0]   srch_w;
	logic                srch_none;
	logic                last_word;
	logic [WCNT_W-1:0]   next_w;
	logic                out_free;

	logic                ram_we;
	logic [MAP_AW-1:0]   ram_waddr;
	word_t               ram_wdata;
	word_t               ram_rdata;
	wop_req_t            wreq;
	wop_rsp_t            wrsp;

	// decode the incoming word
	always_comb begin
		cfg_sat      = (total_blocks > CNT_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS) : total_blocks;
		accept       = in_valid && in_ready;
		misaligned   = (|addr[BLK_SHIFT-1:0]) || (|length[BLK_SHIFT-1:0]);
		first_blk    = addr[ADDR_W-1:BLK_SHIFT];
		stop_raw     = {1'b0, first_blk} + {1'b0, length[ADDR_W-1:BLK_SHIFT]};
		stop_c       = (stop_raw > (BIDX_W+1)'(total_q)) ? (BIDX_W+1)'(total_q) : stop_raw;
		last_blk     = stop_c - 1'b1;
		region_empty = {1'b0, first_blk} >= stop_c;
		rel_in_range = first_blk < BIDX_W'(total_q);
		srch_w       = SRCH_W'(addr[ADDR_W-1:BLK_SHIFT+BIT_W]) +
		               SRCH_W'(|addr[BLK_SHIFT+BIT_W-1:BLK_SHIFT]);
		srch_none    = srch_w >= SRCH_W'(total_q[CNT_W-1:BIT_W]);
		last_word    = (w_q == last_w_q);
		next_w       = WCNT_W'(w_q) + 1'b1;
		out_free     = !out_valid_q || out_ready;
	end

	// word modify request
	always_comb begin
		wreq.data = ram_rdata;
		wreq.lo   = lo_q;
		wreq.hi   = last_word ? hi_last_q : BIT_W'(WORD_BITS - 1);
		wreq.mark = mark_q;
	end

	bfa_word_unit u_word (
		.req (wreq),
		.rsp (wrsp)
	);

	// map write: fill pass or modified word
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = w_q;
		ram_wdata = wrsp.range_word;
		if (state_q == S_FILL) begin
			ram_we    = 1'b1;
			ram_waddr = fill_q;
			ram_wdata = {WORD_BITS{1'b1}};
		end else if (state_q == S_MOD) begin
			ram_we    = alloc_q ? !wrsp.full : 1'b1;
			ram_wdata = alloc_q ? wrsp.alloc_word : wrsp.range_word;
		end
	end

	bfa_map_ram #(
		.DEPTH (MAP_WORDS),
		.WIDTH (WORD_BITS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (state_q == S_RD),
		.raddr (w_q),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			fill_q    <= '0;
			total_q   <= '0;
			used_q    <= '0;
			alloc_q   <= 1'b0;
			mark_q    <= 1'b0;
			w_q       <= '0;
			last_w_q  <= '0;
			lo_q      <= '0;
			hi_last_q <= '0;
			st_q      <= ST_OK;
			raddr_q   <= '0;
		end else if (cfg_we) begin
			state_q <= S_FILL;
			fill_q  <= '0;
			total_q <= cfg_sat;
			used_q  <= cfg_sat;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						st_q    <= ST_OK;
						raddr_q <= '0;
						alloc_q <= (op == OP_ALLOC);
						mark_q  <= (op == OP_RESERVE);
						unique case (op)
							OP_RESERVE, OP_FREE: begin
								w_q       <= first_blk[BLK_W-1:BIT_W];
								lo_q      <= first_blk[BIT_W-1:0];
								last_w_q  <= last_blk[BLK_W-1:BIT_W];
								hi_last_q <= last_blk[BIT_W-1:0];
								if (misaligned) begin
									st_q    <= ST_MISALIGN;
									state_q <= S_DONE;
								end else if (region_empty) begin
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_ALLOC: begin
								w_q  <= srch_w[MAP_AW-1:0];
								lo_q <= '0;
								if ((total_q == used_q) || srch_none) begin
									st_q    <= ST_NOMEM;
									state_q <= S_DONE;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_RELEASE: begin
								w_q       <= first_blk[BLK_W-1:BIT_W];
								lo_q      <= first_blk[BIT_W-1:0];
								last_w_q  <= first_blk[BLK_W-1:BIT_W];
								hi_last_q <= first_blk[BIT_W-1:0];
								state_q   <= rel_in_range ? S_RD : S_DONE;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_FILL: begin
					fill_q <= fill_q + 1'b1;
					if (fill_q == MAP_AW'(MAP_WORDS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_RD: begin
					state_q <= S_MOD;
				end
				S_MOD: begin
					if (alloc_q) begin
						// take the first clear bit, move on to the next word, or stop at the end of the map
						if (!wrsp.full) begin
							used_q  <= used_q + 1'b1;
							raddr_q <= ADDR_W'({w_q, wrsp.zero_idx, {BLK_SHIFT{1'b0}}});
							state_q <= S_DONE;
						end else if (next_w == total_q[CNT_W-1:BIT_W]) begin
							st_q    <= ST_NOMEM;
							state_q <= S_DONE;
						end else begin
							w_q     <= next_w[MAP_AW-1:0];
							state_q <= S_RD;
						end
					end else begin
						// apply the range and adjust the count by the bits changed
						used_q <= mark_q ? used_q + CNT_W'(wrsp.changed)
						                 : used_q - CNT_W'(wrsp.changed);
						lo_q   <= '0;
						if (last_word) begin
							state_q <= S_DONE;
						end else begin
							w_q     <= next_w[MAP_AW-1:0];
							state_q <= S_RD;
						end
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result register: load when the slot is free, drop on handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			status_q      <= st_q;
			result_addr_q <= raddr_q;
			used_count_q  <= used_q;
			free_count_q  <= total_q - used_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign result_addr = result_addr_q;
	assign used_count  = used_count_q;
	assign free_count  = free_count_q;

endmodule

>>> src/bfa_checker.sv
// Port-level checker for the bitmap frame allocator, bound to the top level.
module bfa_checker
	import bfa_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              cfg_we,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [1:0]        status,
	input logic [ADDR_W-1:0] result_addr
);

	// hold a stalled result word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_addr) && $stable(status))
		else $error("result word changed while stalled");

	// a misaligned or out-of-memory result carries a zero address
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == ST_MISALIGN || status == ST_NOMEM) |-> result_addr == '0)
		else $error("failed request returned a non-zero address");

	// allocated addresses lie on a block boundary
	a_addr_align: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> result_addr[BLK_SHIFT-1:0] == '0)
		else $error("allocated address not block aligned");

	// one request in flight at a time
	a_one_op: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("second word accepted while busy");

	// a count write starts the map fill
	a_cfg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> !in_ready)
		else $error("word accepted during map fill");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (.*);
